// ----- rtl/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Shared widths, operation and status codes, and the result record.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int QUEUE_DEPTH_DEF  = 16;
  localparam int PAYLOAD_BITS_DEF = 16;

  localparam int PRIO_W     = 16;
  localparam int TAG_PORT_W = 16;
  localparam int OCC_W      = 5;
  localparam int OP_W       = 2;
  localparam int STATUS_W   = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_APPEND = 2'd1,
    OP_REMOVE = 2'd2
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    status_e                 status;
    logic [OCC_W-1:0]        occupancy;
    logic [TAG_PORT_W-1:0]   payload;
    logic [PRIO_W-1:0]       prio;
  } res_t;

endpackage

// ----- rtl/sorted_priority_queue_top.sv -----
// ----------------------------------------------------------------------------
// Sorted priority queue
// Bounded queue in a ring of RAM slots; a priority insert keeps ascending order.
//
//   channel   direction  tuser          tdata (low bit up)
//   s_axis    in         operation      priority_req, payload
//   m_axis    out        status         out_priority, out_payload, occupancy
//
// One request at a time. A priority insert scans the entries ahead of the new
// one, and a tail insert goes at the end whatever its priority; the scan reads
// one RAM slot per cycle.
// Reset empties the queue at once; the RAM itself is not cleared.
// A stalled output holds the sequencer once its next result is ready.
// ----------------------------------------------------------------------------
module sorted_priority_queue_top
  import spq_pkg::*;
#(
  parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // priority_req[15:0], payload[31:16]
  input  logic [1:0]  s_axis_tuser,   // operation[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // out_priority[15:0], out_payload[31:16],
                                      // occupancy[36:32], zero[39:37]
  output logic [1:0]  m_axis_tuser    // status[1:0]
);

  localparam int TAG_W = (PAYLOAD_BITS < TAG_PORT_W) ? PAYLOAD_BITS : TAG_PORT_W;
  localparam int IDXW  = $clog2(QUEUE_DEPTH);
  localparam int DW    = PRIO_W + TAG_W;

  logic            mem_ren;
  logic [IDXW-1:0] mem_raddr;
  logic            mem_wen;
  logic [IDXW-1:0] mem_waddr;
  logic [DW-1:0]   mem_wdata;
  logic [DW-1:0]   mem_rdata;
  logic            res_valid;
  logic            res_ready;
  res_t            res;
  res_t            m_res;

  spq_ctrl #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .TAG_W      (TAG_W),
    .IDXW       (IDXW),
    .DW         (DW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(s_axis_tvalid),
    .req_ready_o(s_axis_tready),
    .req_op_i   (s_axis_tuser),
    .req_prio_i (s_axis_tdata[PRIO_W-1:0]),
    .req_tag_i  (s_axis_tdata[PRIO_W +: TAG_W]),
    .mem_ren_o  (mem_ren),
    .mem_raddr_o(mem_raddr),
    .mem_wen_o  (mem_wen),
    .mem_waddr_o(mem_waddr),
    .mem_wdata_o(mem_wdata),
    .mem_rdata_i(mem_rdata),
    .res_valid_o(res_valid),
    .res_o      (res),
    .res_ready_i(res_ready)
  );

  spq_mem #(
    .DEPTH(QUEUE_DEPTH),
    .IDXW (IDXW),
    .DW   (DW)
  ) u_mem (
    .clk_i  (clk_i),
    .ren_i  (mem_ren),
    .raddr_i(mem_raddr),
    .wen_i  (mem_wen),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .rdata_o(mem_rdata)
  );

  spq_out u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_valid_i(res_valid),
    .res_i      (res),
    .res_ready_o(res_ready),
    .m_valid_o  (m_axis_tvalid),
    .m_data_o   (m_res),
    .m_ready_i  (m_axis_tready)
  );

  assign m_axis_tdata = {3'b000, m_res.occupancy, m_res.payload, m_res.prio};
  assign m_axis_tuser = m_res.status;

endmodule

// ----- rtl/spq_mem.sv -----
// ----------------------------------------------------------------------------
// Sorted priority queue entry store
// Simple dual-port RAM: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module spq_mem #(
  parameter int DEPTH = 16,
  parameter int IDXW  = 4,
  parameter int DW    = 32
) (
  input  logic            clk_i,
  input  logic            ren_i,
  input  logic [IDXW-1:0] raddr_i,
  input  logic            wen_i,
  input  logic [IDXW-1:0] waddr_i,
  input  logic [DW-1:0]   wdata_i,
  output logic [DW-1:0]   rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wen_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ren_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/spq_ctrl.sv -----
// ----------------------------------------------------------------------------
// Sorted priority queue sequencer
// Keeps the queue as a ring in the entry store. A priority insert walks the
// entries from the head, moving each smaller one down a slot, and drops the
// new entry into the gap; the head pointer then steps back by one.
// ----------------------------------------------------------------------------
module spq_ctrl
  import spq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int TAG_W       = TAG_PORT_W,
  parameter int IDXW        = $clog2(QUEUE_DEPTH),
  parameter int DW          = PRIO_W + TAG_W
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  output logic               req_ready_o,
  input  logic [OP_W-1:0]    req_op_i,
  input  logic [PRIO_W-1:0]  req_prio_i,
  input  logic [TAG_W-1:0]   req_tag_i,
  output logic               mem_ren_o,
  output logic [IDXW-1:0]    mem_raddr_o,
  output logic               mem_wen_o,
  output logic [IDXW-1:0]    mem_waddr_o,
  output logic [DW-1:0]      mem_wdata_o,
  input  logic [DW-1:0]      mem_rdata_i,
  output logic               res_valid_o,
  output res_t               res_o,
  input  logic               res_ready_i
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [IDXW:0]   DEPTH_X = (IDXW+1)'(QUEUE_DEPTH);
  localparam logic [CW-1:0]   DEPTH_C = CW'(QUEUE_DEPTH);
  localparam logic [IDXW-1:0] LAST_IDX = IDXW'(QUEUE_DEPTH - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_TAIL,
    S_RDHEAD,
    S_POP,
    S_DONE
  } state_e;

  state_e            state_q;
  logic [IDXW-1:0]   head_q;
  logic [CW-1:0]     cnt_q;
  logic [CW-1:0]     rk_q;
  logic [CW-1:0]     ck_q;
  logic              dv_q;
  res_t              res_q;
  logic [PRIO_W-1:0] req_prio_q;
  logic [TAG_W-1:0]  req_tag_q;

  logic [IDXW-1:0]   hm1;
  logic [PRIO_W-1:0] rd_prio;
  logic [TAG_W-1:0]  rd_tag;
  logic              hit;
  logic              scan_end;
  logic              scan_rd;
  logic              full;
  op_e               req_op;
  status_e           idle_st;
  logic [DW-1:0]     new_entry;

  function automatic logic [IDXW-1:0] wrap_idx(input logic [IDXW:0] x);
    logic [IDXW:0] y;
    y = (x >= DEPTH_X) ? (x - DEPTH_X) : x;
    return y[IDXW-1:0];
  endfunction

  always_comb begin
    hm1       = (head_q == '0) ? LAST_IDX : (head_q - 1'b1);
    rd_prio   = mem_rdata_i[PRIO_W-1:0];
    rd_tag    = mem_rdata_i[DW-1:PRIO_W];
    // first entry whose priority is not smaller marks the insert point
    hit       = dv_q && (rd_prio >= req_prio_q);
    scan_end  = !dv_q && (rk_q == cnt_q);
    scan_rd   = !hit && (rk_q < cnt_q);
    full      = (cnt_q == DEPTH_C);
    req_op    = op_e'(req_op_i);
    idle_st   = ((req_op inside {OP_INSERT, OP_APPEND}) && full) ? ST_FULL :
                ((req_op == OP_REMOVE) && (cnt_q == '0))         ? ST_EMPTY :
                                                                    ST_DONE;
    new_entry = {req_tag_q, req_prio_q};
  end

  always_comb begin
    mem_ren_o   = 1'b0;
    mem_raddr_o = head_q;
    mem_wen_o   = 1'b0;
    mem_waddr_o = head_q;
    mem_wdata_o = new_entry;
    case (state_q)
      S_SCAN: begin
        mem_ren_o   = scan_rd;
        mem_raddr_o = wrap_idx({1'b0, head_q} + (IDXW+1)'(rk_q));
        mem_wen_o   = dv_q || scan_end;
        // logical slot one below the entry just looked at
        mem_waddr_o = wrap_idx({1'b0, hm1} + (IDXW+1)'(scan_end ? cnt_q : ck_q));
        mem_wdata_o = (hit || scan_end) ? new_entry : mem_rdata_i;
      end
      S_TAIL: begin
        mem_wen_o   = 1'b1;
        mem_waddr_o = wrap_idx({1'b0, head_q} + (IDXW+1)'(cnt_q));
      end
      S_RDHEAD: begin
        mem_ren_o = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (req_valid_i && req_ready_o) begin
      req_prio_q <= req_prio_i;
      req_tag_q  <= req_tag_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      cnt_q   <= '0;
      rk_q    <= '0;
      ck_q    <= '0;
      dv_q    <= 1'b0;
      res_q   <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (req_valid_i) begin
            rk_q  <= '0;
            dv_q  <= 1'b0;
            res_q <= '{status: idle_st, occupancy: OCC_W'(cnt_q),
                       payload: '0, prio: '0};
            case (req_op)
              OP_INSERT, OP_APPEND: begin
                if (full) begin
                  state_q <= S_DONE;
                end else if (req_op == OP_INSERT) begin
                  state_q <= S_SCAN;
                end else begin
                  state_q <= S_TAIL;
                end
              end
              OP_REMOVE: begin
                if (cnt_q == '0) begin
                  state_q <= S_DONE;
                end else begin
                  state_q <= S_RDHEAD;
                end
              end
              default: begin
                state_q <= S_DONE;
              end
            endcase
          end
        end
        S_SCAN: begin
          rk_q <= rk_q + CW'(scan_rd);
          dv_q <= scan_rd;
          ck_q <= rk_q;
          if (hit || scan_end) begin
            head_q          <= hm1;
            cnt_q           <= cnt_q + 1'b1;
            res_q.occupancy <= OCC_W'(cnt_q + 1'b1);
            state_q         <= S_DONE;
          end
        end
        S_TAIL: begin
          cnt_q           <= cnt_q + 1'b1;
          res_q.occupancy <= OCC_W'(cnt_q + 1'b1);
          state_q         <= S_DONE;
        end
        S_RDHEAD: begin
          state_q <= S_POP;
        end
        S_POP: begin
          res_q   <= '{status: ST_DONE, occupancy: OCC_W'(cnt_q - 1'b1),
                       payload: TAG_PORT_W'(rd_tag), prio: rd_prio};
          cnt_q   <= cnt_q - 1'b1;
          head_q  <= wrap_idx({1'b0, head_q} + 1'b1);
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (res_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign req_ready_o = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;

endmodule

// ----- rtl/spq_out.sv -----
// ----------------------------------------------------------------------------
// Sorted priority queue result register
// Holds one finished result until the downstream side takes the transfer.
// ----------------------------------------------------------------------------
module spq_out
  import spq_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic res_valid_i,
  input  res_t res_i,
  output logic res_ready_o,
  output logic m_valid_o,
  output res_t m_data_o,
  input  logic m_ready_i
);

  logic valid_q;
  res_t data_q;

  assign res_ready_o = !valid_q || m_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (res_ready_o) begin
      valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i && res_ready_o) begin
      data_q <= res_i;
    end
  end

  assign m_valid_o = valid_q;
  assign m_data_o  = data_q;

endmodule

// ----- rtl/spq_checker.sv -----
// ----------------------------------------------------------------------------
// Sorted priority queue port checker
// Watches the top-level streams and flags results that cannot be right.
// ----------------------------------------------------------------------------
module spq_checker
  import spq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  // an empty report only comes from an empty queue
  a_empty_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_EMPTY) |-> m_axis_tdata[36:32] == '0)
    else $error("empty status with nonzero occupancy");

  // a dropped insert only comes from a full queue
  a_full_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_FULL) |->
      m_axis_tdata[36:32] == OCC_W'(QUEUE_DEPTH))
    else $error("full status below capacity");

  // a request is not taken twice in a row
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("back-to-back request transfers");

  // hold the result while it is stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

endmodule

bind sorted_priority_queue_top spq_checker #(
  .QUEUE_DEPTH(QUEUE_DEPTH)
) u_spq_checker (.*);

// ----- tb/sorted_priority_queue_top_tb.sv -----
// ----------------------------------------------------------------------------
// Sorted priority queue testbench
// Drives priority inserts, tail inserts, removes and the unused code through
// the request stream, keeps a shadow copy of the queue to predict each result,
// and compares every result transfer field by field under varying back-pressure.
// ----------------------------------------------------------------------------
module sorted_priority_queue_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import spq_pkg::*;

  localparam int DEPTH          = QUEUE_DEPTH_DEF;
  localparam int TAG_KEEP       = (PAYLOAD_BITS_DEF < TAG_PORT_W) ? PAYLOAD_BITS_DEF
                                                                  : TAG_PORT_W;
  localparam logic [TAG_PORT_W-1:0] TAG_MASK = {TAG_PORT_W{1'b1}} >> (TAG_PORT_W - TAG_KEEP);
  localparam logic [OP_W-1:0] OP_IGNORED = 2'd3;
  localparam int ITEMS_PER_PHASE = 300;
  localparam int SETTLE_CYCLES   = 2 * DEPTH + 16;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int SRC_IDLE  [4]   = '{0, 52, 0, 34};
  localparam int RCV_STALL [4]   = '{0, 0, 52, 34};

  // Shadow of the queue contents; predicts one result per request
  class prio_queue_shadow;
    logic [PRIO_W-1:0]     slot_prio[DEPTH];
    logic [TAG_PORT_W-1:0] slot_tag[DEPTH];
    int unsigned           held;
    res_t                  owed[$];
    int unsigned           fails;

    function new();
      held  = 0;
      fails = 0;
    endfunction

    function void note_request(logic [OP_W-1:0] op, logic [PRIO_W-1:0] prio,
                               logic [TAG_PORT_W-1:0] tag);
      res_t        r;
      int unsigned pos;
      int unsigned i;
      r = '0;
      if (op == OP_INSERT || op == OP_APPEND) begin
        if (held >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          pos = held;
          if (op == OP_INSERT) begin
            // stop at the first entry that is not smaller: ties go in front
            pos = 0;
            while (pos < held && slot_prio[pos] < prio) pos++;
          end
          for (i = held; i > pos; i--) begin
            slot_prio[i] = slot_prio[i-1];
            slot_tag[i]  = slot_tag[i-1];
          end
          slot_prio[pos] = prio;
          slot_tag[pos]  = tag & TAG_MASK;
          held++;
        end
      end else if (op == OP_REMOVE) begin
        if (held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.prio    = slot_prio[0];
          r.payload = slot_tag[0];
          for (i = 1; i < held; i++) begin
            slot_prio[i-1] = slot_prio[i];
            slot_tag[i-1]  = slot_tag[i];
          end
          held--;
        end
      end
      r.occupancy = OCC_W'(held);
      owed.push_back(r);
    endfunction

    function void check_result(logic [STATUS_W-1:0] status, logic [PRIO_W-1:0] prio,
                               logic [TAG_PORT_W-1:0] tag, logic [OCC_W-1:0] occ);
      res_t want;
      if (owed.size() == 0) begin
        $display("%0t: result with nothing owed, actual status %0d prio %h tag %h occ %0d",
                 $time, status, prio, tag, occ);
        fails++;
        return;
      end
      want = owed.pop_front();
      if (status !== want.status) begin
        $display("%0t: status mismatch, expected %0d, actual %0d", $time, want.status, status);
        fails++;
      end
      if (prio !== want.prio) begin
        $display("%0t: out_priority mismatch, expected %h, actual %h", $time, want.prio, prio);
        fails++;
      end
      if (tag !== want.payload) begin
        $display("%0t: out_payload mismatch, expected %h, actual %h", $time, want.payload, tag);
        fails++;
      end
      if (occ !== want.occupancy) begin
        $display("%0t: occupancy mismatch, expected %0d, actual %0d", $time, want.occupancy,
                 occ);
        fails++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // priority_req[15:0], payload[31:16]
  logic [1:0]  s_axis_tuser;   // operation[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;   // out_priority[15:0], out_payload[31:16], occupancy[36:32]
  logic [1:0]  m_axis_tuser;   // status[1:0]

  prio_queue_shadow shadow = new();
  int               src_idle_pct  = 0;
  int               rcv_stall_pct = 0;
  int               quiet_cycles  = 0;

  sorted_priority_queue_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Result side: check transfers, randomise back-pressure, watch for a hang
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      shadow.check_result(m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[31:16],
                          m_axis_tdata[36:32]);
    end
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
      $display("CHECKS FAILED");
      $finish;
    end
    m_axis_tready <= ($urandom_range(99) >= rcv_stall_pct);
  end

  task automatic send_request(input logic [OP_W-1:0] op, input logic [PRIO_W-1:0] prio,
                              input logic [TAG_PORT_W-1:0] tag);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < src_idle_pct) gap++;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {tag, prio};
    do @(posedge clk_i); while (!s_axis_tready);
    shadow.note_request(op, prio, tag);
  endtask

  // Hold the request stream until every owed result has come back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (shadow.owed.size() != 0) @(posedge clk_i);
  endtask

  task automatic run_random(input int unsigned count);
    logic [OP_W-1:0]       op;
    logic [PRIO_W-1:0]     prio;
    logic [TAG_PORT_W-1:0] tag;
    int unsigned           fill_pct;
    int unsigned           roll;
    int unsigned           n;
    fill_pct = 60;
    for (n = 0; n < count; n++) begin
      // swing between filling and draining bursts so both full and empty are reached
      if (n % 40 == 0) fill_pct = $urandom_range(80, 25);
      roll = $urandom_range(99);
      if (roll < 3) begin
        op = OP_IGNORED;
      end else if (roll < fill_pct) begin
        op = ($urandom_range(3) == 0) ? OP_APPEND : OP_INSERT;
      end else begin
        op = OP_REMOVE;
      end
      case ($urandom_range(3))
        0:       prio = PRIO_W'($urandom_range(7));
        1:       prio = 16'hFFF8 | PRIO_W'($urandom_range(7));
        default: prio = PRIO_W'($urandom);
      endcase
      tag = TAG_PORT_W'($urandom);
      send_request(op, prio, tag);
    end
  endtask

  initial begin
    int i;
    int ph;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    m_axis_tready <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(OP_REMOVE, 16'hFFFF, 16'hFFFF);   // empty queue
    send_request(OP_IGNORED, 16'hFFFF, 16'hFFFF);  // unused code leaves the queue alone
    send_request(OP_INSERT, 16'hFFFF, 16'hFFFF);
    send_request(OP_INSERT, 16'h0000, 16'h0000);
    send_request(OP_INSERT, 16'h8000, 16'hA5A5);
    send_request(OP_INSERT, 16'h8000, 16'h5A5A);   // equal priority goes ahead
    send_request(OP_APPEND, 16'h0001, 16'h1234);   // tail ignores priority
    send_request(OP_INSERT, 16'hFFFF, 16'h0F0F);
    for (i = 0; i < DEPTH - 6; i++) begin
      send_request((i % 2 != 0) ? OP_APPEND : OP_INSERT, PRIO_W'(i * 6007), TAG_PORT_W'(i));
    end
    send_request(OP_INSERT, 16'h0000, 16'hFFFF);   // full: dropped
    send_request(OP_APPEND, 16'hFFFF, 16'h0000);   // full: dropped
    send_request(OP_IGNORED, 16'h0000, 16'h0000);
    send_request(OP_REMOVE, 16'h0000, 16'h0000);
    send_request(OP_REMOVE, 16'h0000, 16'h0000);
    drain_results();

    for (ph = 0; ph < 4; ph++) begin
      src_idle_pct  = SRC_IDLE[ph];
      rcv_stall_pct = RCV_STALL[ph];
      run_random(ITEMS_PER_PHASE);
      drain_results();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (shadow.fails == 0 && shadow.owed.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
